// ===== rtl/dss_pkg.sv =====
// Shared types, constants and the microprogram of the dynamic two-pole smoother.
// Used by dss_sequencer, dss_datapath and dynamic_svf_smoother; depends on nothing.
`default_nettype none

package dss_pkg;

  // Number formats
  localparam int DATA_W  = 32;                // Q16.16 samples
  localparam int STATE_W = 48;                // saturating stage states
  localparam int GUARD_W = STATE_W - DATA_W;  // extra fraction bits in the states
  localparam int STEP_W  = 5;                 // microprogram address

  // Gain and frequency limits (32 fraction bits)
  localparam logic [32:0] GAIN_ONE = 33'h1_0000_0000;
  localparam logic [33:0] TERM_CAP = 34'h2_0000_0000;
  localparam logic [31:0] WD_CAP   = 32'h8000_0000;

  // Cubic coefficients, 28 fraction bits
  localparam logic [31:0] POLY_C1 = 32'd1609239071;
  localparam logic [31:0] POLY_C2 = 32'd3212983430;
  localparam logic [31:0] POLY_C3 = 32'd4283978085;

  // Register indexes
  localparam logic [1:0] REG_MODE      = 2'd0;
  localparam logic [1:0] REG_BASE_GAIN = 2'd1;
  localparam logic [1:0] REG_SLOPE     = 2'd2;
  localparam logic [1:0] REG_FREQ      = 2'd3;

  // Reset values of the registers
  localparam logic [32:0] BASE_GAIN_RST = 33'd1124420;
  localparam logic [31:0] SLOPE_RST     = 32'd2097152;
  localparam logic [31:0] FREQ_RST      = 32'd178957;

  // Datapath operations, one per microprogram step
  typedef enum logic [4:0] {
    OP_NOP,
    OP_LOAD,     // take the item, band = s1 - s2
    OP_MAG,      // magnitude and sign of the difference
    OP_MUL_LO,   // low 32 bits of magnitude times B operand
    OP_MUL_HI,   // high bits of magnitude times B operand
    OP_TERM,     // slope term, capped
    OP_GAIN,     // linear gain or dynamic frequency, stage one input
    OP_CUB_T,    // C3 * w
    OP_CUB_U,    // u = t - C2
    OP_CUB_UW,   // u * w
    OP_CUB_V,    // v = C1 + floor(u * w), clamped at zero
    OP_CUB_VW,   // v * w
    OP_CUB_G,    // cubic gain, capped
    OP_D1,       // stage one difference
    OP_SCALE,    // signed gain product
    OP_UPD1,     // stage one update
    OP_IN2,      // stage two input
    OP_D2,       // stage two difference
    OP_UPD2,     // stage two update, keep target
    OP_OUT       // load the output register
  } op_e;

  // Multiplier B operand
  typedef enum logic [1:0] {
    B_SLOPE,
    B_GAIN,
    B_FREQ
  } bsel_e;

  // Jump conditions
  typedef enum logic [1:0] {
    J_NONE,
    J_NO_INPUT,
    J_LINEAR,
    J_OUT_BUSY
  } cond_e;

  typedef struct packed {
    op_e               op;
    bsel_e             bsel;
    cond_e             cond;
    logic [STEP_W-1:0] target;
    logic              last;
  } ctrl_t;

  typedef struct packed {
    logic in_valid;
    logic linear;
    logic out_busy;
  } status_t;

  typedef struct packed {
    logic        mode;
    logic [32:0] base_gain;
    logic [31:0] slope_gain;
    logic [31:0] base_freq_ratio;
  } cfg_t;

  // Program labels
  localparam logic [STEP_W-1:0] STEP_IDLE   = 5'd0;
  localparam logic [STEP_W-1:0] STEP_STAGE1 = 5'd12;
  localparam logic [STEP_W-1:0] STEP_OUT    = 5'd25;
  localparam logic [STEP_W-1:0] LAST_STEP   = STEP_OUT;

  function automatic ctrl_t cw(input op_e op, input bsel_e bsel, input cond_e cond,
                               input logic [STEP_W-1:0] target, input logic last);
    ctrl_t c;
    c.op     = op;
    c.bsel   = bsel;
    c.cond   = cond;
    c.target = target;
    c.last   = last;
    return c;
  endfunction

  // Microprogram ROM
  function automatic ctrl_t ucode(input logic [STEP_W-1:0] step);
    ctrl_t c;
    case (step)
      5'd0:    c = cw(OP_LOAD,   B_SLOPE, J_NO_INPUT, STEP_IDLE,   1'b0);
      5'd1:    c = cw(OP_MAG,    B_SLOPE, J_NONE,     STEP_IDLE,   1'b0);
      5'd2:    c = cw(OP_MUL_LO, B_SLOPE, J_NONE,     STEP_IDLE,   1'b0);
      5'd3:    c = cw(OP_MUL_HI, B_SLOPE, J_NONE,     STEP_IDLE,   1'b0);
      5'd4:    c = cw(OP_TERM,   B_SLOPE, J_NONE,     STEP_IDLE,   1'b0);
      5'd5:    c = cw(OP_GAIN,   B_SLOPE, J_LINEAR,   STEP_STAGE1, 1'b0);
      5'd6:    c = cw(OP_CUB_T,  B_FREQ,  J_NONE,     STEP_IDLE,   1'b0);
      5'd7:    c = cw(OP_CUB_U,  B_FREQ,  J_NONE,     STEP_IDLE,   1'b0);
      5'd8:    c = cw(OP_CUB_UW, B_FREQ,  J_NONE,     STEP_IDLE,   1'b0);
      5'd9:    c = cw(OP_CUB_V,  B_FREQ,  J_NONE,     STEP_IDLE,   1'b0);
      5'd10:   c = cw(OP_CUB_VW, B_FREQ,  J_NONE,     STEP_IDLE,   1'b0);
      5'd11:   c = cw(OP_CUB_G,  B_FREQ,  J_NONE,     STEP_IDLE,   1'b0);
      5'd12:   c = cw(OP_D1,     B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd13:   c = cw(OP_MAG,    B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd14:   c = cw(OP_MUL_LO, B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd15:   c = cw(OP_MUL_HI, B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd16:   c = cw(OP_SCALE,  B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd17:   c = cw(OP_UPD1,   B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd18:   c = cw(OP_IN2,    B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd19:   c = cw(OP_D2,     B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd20:   c = cw(OP_MAG,    B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd21:   c = cw(OP_MUL_LO, B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd22:   c = cw(OP_MUL_HI, B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd23:   c = cw(OP_SCALE,  B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd24:   c = cw(OP_UPD2,   B_GAIN,  J_NONE,     STEP_IDLE,   1'b0);
      5'd25:   c = cw(OP_OUT,    B_GAIN,  J_OUT_BUSY, STEP_OUT,    1'b1);
      default: c = cw(OP_NOP,    B_SLOPE, J_NONE,     STEP_IDLE,   1'b1);
    endcase
    return c;
  endfunction

endpackage

`default_nettype wire

// ===== rtl/dynamic_svf_smoother.sv =====
// Dynamic two-pole smoother: one smoothed sample per target item.
// A new target item is taken only at the load step, after the microprogram has finished the last one;
// every multiply runs through one shared 34x34 multiplier, and a stalled output holds the program
// at its output step until the output register is free.
// Reset: stage states and previous target cleared, registers to defaults, no clearing pass.
// Top level: APB-style registers, stream handshake, sequencer and datapath; uses dss_pkg.
`default_nettype none

module dynamic_svf_smoother (
  input  logic        clk_i,
  input  logic        rst_ni,
  // input items
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // [31:0] target
  // result items
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // [31:0] smoothed
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  dss_pkg::cfg_t    cfg_q;
  dss_pkg::ctrl_t   ctrl;
  dss_pkg::status_t status;
  logic             cfg_wr;
  logic             out_busy;
  logic [1:0]       reg_idx;

  // Register writes
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign reg_idx = paddr[4:3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.mode            <= 1'b0;
      cfg_q.base_gain       <= dss_pkg::BASE_GAIN_RST;
      cfg_q.slope_gain      <= dss_pkg::SLOPE_RST;
      cfg_q.base_freq_ratio <= dss_pkg::FREQ_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        dss_pkg::REG_MODE:      cfg_q.mode            <= pwdata[0];
        dss_pkg::REG_BASE_GAIN: cfg_q.base_gain       <= pwdata[32:0];
        dss_pkg::REG_SLOPE:     cfg_q.slope_gain      <= pwdata[31:0];
        dss_pkg::REG_FREQ:      cfg_q.base_freq_ratio <= pwdata[31:0];
        default: ;
      endcase
    end
  end

  // Register reads
  always_comb begin
    case (reg_idx)
      dss_pkg::REG_MODE:      prdata = {63'd0, cfg_q.mode};
      dss_pkg::REG_BASE_GAIN: prdata = {31'd0, cfg_q.base_gain};
      dss_pkg::REG_SLOPE:     prdata = {32'd0, cfg_q.slope_gain};
      dss_pkg::REG_FREQ:      prdata = {32'd0, cfg_q.base_freq_ratio};
      default:                prdata = '0;
    endcase
  end

  // Input is taken only at the load step
  assign s_axis_tready   = (ctrl.op == dss_pkg::OP_LOAD);
  assign status.in_valid = s_axis_tvalid;
  assign status.linear   = !cfg_q.mode;
  assign status.out_busy = out_busy;

  dss_sequencer u_seq (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .status_i (status),
    .ctrl_o   (ctrl)
  );

  dss_datapath u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .ctrl_i      (ctrl),
    .cfg_i       (cfg_q),
    .in_valid_i  (s_axis_tvalid),
    .target_i    ($signed(s_axis_tdata)),
    .out_ready_i (m_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .smoothed_o  (m_axis_tdata),
    .out_busy_o  (out_busy)
  );

endmodule

`default_nettype wire

// ===== rtl/dss_sequencer.sv =====
// Step counter and microprogram ROM of the smoother; issues one control word a cycle.
// Depends on dss_pkg.
`default_nettype none

module dss_sequencer (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  dss_pkg::status_t status_i,
  output dss_pkg::ctrl_t   ctrl_o
);

  logic [dss_pkg::STEP_W-1:0] step_q, step_d;
  logic                       jump;

  // Current control word
  assign ctrl_o = dss_pkg::ucode(step_q);

  // Jump condition and next step
  always_comb begin
    case (ctrl_o.cond)
      dss_pkg::J_NONE:     jump = 1'b0;
      dss_pkg::J_NO_INPUT: jump = !status_i.in_valid;
      dss_pkg::J_LINEAR:   jump = status_i.linear;
      dss_pkg::J_OUT_BUSY: jump = status_i.out_busy;
      default:             jump = 1'b0;
    endcase
    if (jump) begin
      step_d = ctrl_o.target;
    end else if (ctrl_o.last) begin
      step_d = dss_pkg::STEP_IDLE;
    end else begin
      step_d = step_q + 1'b1;
    end
  end

  // Step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      step_q <= dss_pkg::STEP_IDLE;
    end else begin
      step_q <= step_d;
    end
  end

`ifndef NO_ASSERTIONS
  a_step_in_program: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step_q <= dss_pkg::LAST_STEP)
    else $error("step counter left the program");

  a_out_returns_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_o.op == dss_pkg::OP_OUT && !status_i.out_busy) |=> (step_q == dss_pkg::STEP_IDLE))
    else $error("sequencer did not return to idle after output");
`endif

endmodule

`default_nettype wire

// ===== rtl/dss_datapath.sv =====
// Datapath of the smoother: stage states, work registers, one shared 34x34 multiplier
// and the output register, all steered by the control word. Depends on dss_pkg.
`default_nettype none

module dss_datapath (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  dss_pkg::ctrl_t                    ctrl_i,
  input  dss_pkg::cfg_t                     cfg_i,
  input  logic                              in_valid_i,
  input  logic signed [dss_pkg::DATA_W-1:0] target_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [dss_pkg::DATA_W-1:0] smoothed_o,
  output logic                              out_busy_o
);

  // Saturate a wide sum to the state width
  function automatic logic signed [47:0] sat_state(input logic signed [49:0] v);
    logic signed [47:0] r;
    if (v[49:47] == 3'b000 || v[49:47] == 3'b111) begin
      r = v[47:0];
    end else if (v[49]) begin
      r = {1'b1, {47{1'b0}}};
    end else begin
      r = {1'b0, {47{1'b1}}};
    end
    return r;
  endfunction

  // Average rounded toward minus infinity
  function automatic logic signed [47:0] avg_floor(input logic signed [47:0] a,
                                                   input logic signed [47:0] b);
    logic signed [48:0] s;
    s = 49'(a) + 49'(b);
    return s[48:1];
  endfunction

  // Model state
  logic signed [47:0] s1_q, s1_d, s2_q, s2_d;
  logic signed [31:0] prior_q, prior_d;
  // Work registers
  logic signed [31:0] x_q, x_d;
  logic signed [47:0] d_q, d_d, in_q, in_d, old1_q, old1_d;
  logic        [47:0] m_q, m_d;
  logic               neg_q, neg_d;
  logic signed [67:0] p_q, p_d;
  logic        [64:0] lo_q, lo_d;
  logic        [33:0] term_q, term_d;
  logic        [32:0] g_q, g_d;
  logic        [31:0] w_q, w_d, v_q, v_d;
  logic signed [33:0] u_q, u_d;
  logic signed [48:0] sr_q, sr_d;
  // Output register
  logic signed [31:0] out_data_q, out_data_d;
  logic               out_valid_q, out_valid_d;

  logic signed [33:0] mul_a, mul_b;
  logic signed [67:0] mul_p;
  logic signed [47:0] xs, prior_s;
  logic        [52:0] term_sum;
  logic        [34:0] gsum;
  logic signed [36:0] vsum;
  logic        [49:0] rmag;
  logic               out_free, out_load;

  assign xs      = $signed({x_q, {dss_pkg::GUARD_W{1'b0}}});
  assign prior_s = $signed({prior_q, {dss_pkg::GUARD_W{1'b0}}});
  assign out_free = !out_valid_q || out_ready_i;

  // Multiplier operands
  always_comb begin
    case (ctrl_i.op)
      dss_pkg::OP_MUL_LO: mul_a = $signed({2'b00, m_q[31:0]});
      dss_pkg::OP_MUL_HI: mul_a = $signed({18'd0, m_q[47:32]});
      dss_pkg::OP_CUB_T:  mul_a = $signed({2'b00, dss_pkg::POLY_C3});
      dss_pkg::OP_CUB_UW: mul_a = u_q;
      dss_pkg::OP_CUB_VW: mul_a = $signed({2'b00, v_q});
      default:            mul_a = '0;
    endcase
    case (ctrl_i.bsel)
      dss_pkg::B_SLOPE: mul_b = $signed({2'b00, cfg_i.slope_gain});
      dss_pkg::B_GAIN:  mul_b = $signed({1'b0, g_q});
      dss_pkg::B_FREQ:  mul_b = $signed({2'b00, w_q});
      default:          mul_b = '0;
    endcase
  end

  assign mul_p = 68'(mul_a) * 68'(mul_b);

  // Operation decode
  always_comb begin
    s1_d       = s1_q;
    s2_d       = s2_q;
    prior_d    = prior_q;
    x_d        = x_q;
    d_d        = d_q;
    in_d       = in_q;
    old1_d     = old1_q;
    m_d        = m_q;
    neg_d      = neg_q;
    p_d        = p_q;
    lo_d       = lo_q;
    term_d     = term_q;
    g_d        = g_q;
    w_d        = w_q;
    v_d        = v_q;
    u_d        = u_q;
    sr_d       = sr_q;
    out_data_d = out_data_q;
    out_load   = 1'b0;
    term_sum   = {1'b0, p_q[47:0], 4'b0000} + {16'd0, lo_q[64:28]};
    gsum       = cfg_i.mode ? (35'(cfg_i.base_freq_ratio) + 35'(term_q))
                            : (35'(cfg_i.base_gain) + 35'(term_q));
    vsum       = $signed({5'd0, dss_pkg::POLY_C1}) + 37'($signed(p_q[67:32]));
    rmag       = {1'b0, p_q[48:0]} + {17'd0, lo_q[64:32]};
    case (ctrl_i.op)
      dss_pkg::OP_LOAD: begin
        if (in_valid_i) begin
          x_d = target_i;
          d_d = sat_state(50'(s1_q) - 50'(s2_q));
        end
      end
      dss_pkg::OP_MAG: begin
        neg_d = d_q[47];
        m_d   = d_q[47] ? $unsigned(-d_q) : $unsigned(d_q);
      end
      dss_pkg::OP_MUL_LO: p_d = mul_p;
      dss_pkg::OP_MUL_HI: begin
        p_d  = mul_p;
        lo_d = p_q[64:0];
      end
      dss_pkg::OP_TERM: begin
        term_d = (term_sum > 53'(dss_pkg::TERM_CAP)) ? dss_pkg::TERM_CAP : term_sum[33:0];
      end
      dss_pkg::OP_GAIN: begin
        // linear: gain straight away; cubic: capped frequency and averaged input
        if (!cfg_i.mode) begin
          g_d  = (gsum > 35'(dss_pkg::GAIN_ONE)) ? dss_pkg::GAIN_ONE : gsum[32:0];
          in_d = xs;
        end else begin
          w_d  = (gsum > 35'(dss_pkg::WD_CAP)) ? dss_pkg::WD_CAP : gsum[31:0];
          in_d = avg_floor(xs, prior_s);
        end
      end
      dss_pkg::OP_CUB_T: p_d = mul_p;
      dss_pkg::OP_CUB_U: begin
        u_d = $signed({2'b00, p_q[63:32]}) - $signed({2'b00, dss_pkg::POLY_C2});
      end
      dss_pkg::OP_CUB_UW: p_d = mul_p;
      dss_pkg::OP_CUB_V: v_d = vsum[36] ? '0 : vsum[31:0];
      dss_pkg::OP_CUB_VW: p_d = mul_p;
      dss_pkg::OP_CUB_G: begin
        g_d = (p_q[67:28] > 40'(dss_pkg::GAIN_ONE)) ? dss_pkg::GAIN_ONE : p_q[60:28];
      end
      dss_pkg::OP_D1: begin
        d_d    = sat_state(50'(in_q) - 50'(s1_q));
        old1_d = s1_q;
      end
      dss_pkg::OP_SCALE: begin
        // product truncated toward zero, sign put back afterwards
        sr_d = neg_q ? -$signed(rmag[48:0]) : $signed(rmag[48:0]);
      end
      dss_pkg::OP_UPD1: s1_d = sat_state(50'(s1_q) + 50'(sr_q));
      dss_pkg::OP_IN2: in_d = cfg_i.mode ? avg_floor(s1_q, old1_q) : s1_q;
      dss_pkg::OP_D2: d_d = sat_state(50'(in_q) - 50'(s2_q));
      dss_pkg::OP_UPD2: begin
        s2_d    = sat_state(50'(s2_q) + 50'(sr_q));
        prior_d = x_q;
      end
      dss_pkg::OP_OUT: begin
        if (out_free) begin
          out_data_d = s2_q[dss_pkg::STATE_W-1:dss_pkg::GUARD_W];
          out_load   = 1'b1;
        end
      end
      default: ;
    endcase
    if (out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  // State and output valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q        <= '0;
      s2_q        <= '0;
      prior_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      s1_q        <= s1_d;
      s2_q        <= s2_d;
      prior_q     <= prior_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Work registers
  always_ff @(posedge clk_i) begin
    x_q        <= x_d;
    d_q        <= d_d;
    in_q       <= in_d;
    old1_q     <= old1_d;
    m_q        <= m_d;
    neg_q      <= neg_d;
    p_q        <= p_d;
    lo_q       <= lo_d;
    term_q     <= term_d;
    g_q        <= g_d;
    w_q        <= w_d;
    v_q        <= v_d;
    u_q        <= u_d;
    sr_q       <= sr_d;
    out_data_q <= out_data_d;
  end

  assign out_valid_o = out_valid_q;
  assign smoothed_o  = out_data_q;
  assign out_busy_o  = !out_free;

`ifndef NO_ASSERTIONS
  a_gain_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == dss_pkg::OP_D1) |-> (g_q <= dss_pkg::GAIN_ONE))
    else $error("stage gain above one");

  a_freq_capped: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == dss_pkg::OP_CUB_T) |-> (w_q <= dss_pkg::WD_CAP))
    else $error("dynamic frequency above its cap");

  a_out_loaded: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (ctrl_i.op == dss_pkg::OP_OUT && out_free) |=> out_valid_q)
    else $error("output register not loaded");
`endif

endmodule

`default_nettype wire
